// File: rtl/core/rrqs_pkg.sv
package rrqs_pkg;

	localparam int ID_W            = 4;
	localparam int QV_IN_W         = 8;
	localparam int TICKS_OUT_W     = 8;
	localparam int CNT_OUT_W       = 5;
	localparam int INIT_SLICE      = 10;
	localparam int RESET_TASK      = 1;

	typedef enum logic [1:0] {
		REQ_TICK        = 2'd0,
		REQ_MAKE_READY  = 2'd1,
		REQ_BLOCK       = 2'd2,
		REQ_SET_QUANTUM = 2'd3
	} req_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_cmd_t;

endpackage

// File: rtl/core/rrqs_fifo_mem.sv
module rrqs_fifo_mem import rrqs_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  mem_cmd_t        cmd,
	input  logic [AW-1:0]   rd_addr,
	input  logic [AW-1:0]   wr_addr,
	input  logic [ID_W-1:0] wr_data,
	output logic [ID_W-1:0] rd_data
);

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/rrqs_qtab_mem.sv
module rrqs_qtab_mem import rrqs_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int QW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mem_cmd_t      cmd,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [QW-1:0] wr_data,
	output logic [QW-1:0] rd_data
);

	logic [QW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [QW-1:0]    rd_word_q;
	logic             rd_hit_q;

	// An entry that was never written since reset reads as the default quantum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_word_q <= mem[rd_addr];
			rd_hit_q  <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_hit_q ? rd_word_q : QW'(INIT_SLICE);

endmodule

// File: rtl/core/round_robin_quantum_scheduler.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid / in_ready       req_type, task_id, quantum_value
// out       output     out_valid / out_ready     switched, running_task, remaining_ticks,
//                                                ready_count, status
// cfg       input      cfg_wr_en (no wait)       cfg_wr_data (idle task id)
//
// An item goes through the execute state to its registered result, and also through
// the load state when it dispatches a new task, since the quantum memory is read with
// the id just read from the ready FIFO. A new item is taken once the sequencer is idle again.
// Reset takes effect at once; the quantum table reads as its default until written.
// One item is taken while a result waits; its last step then holds until out_ready.
module round_robin_quantum_scheduler import rrqs_pkg::*; #(
	parameter int NUM_TASKS     = 16,
	parameter int QUANTUM_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [ID_W-1:0]        cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [ID_W-1:0]        task_id,
	input  logic [QV_IN_W-1:0]     quantum_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   switched,
	output logic [ID_W-1:0]        running_task,
	output logic [TICKS_OUT_W-1:0] remaining_ticks,
	output logic [CNT_OUT_W-1:0]   ready_count,
	output logic                   status
);

	localparam int IDX_W = $clog2(NUM_TASKS);
	localparam int CNT_W = $clog2(NUM_TASKS + 1);
	localparam int QW    = QUANTUM_WIDTH;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_TASKS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	function automatic logic in_range(input logic [ID_W-1:0] id);
		return 32'(id) < NUM_TASKS;
	endfunction

	function automatic logic [IDX_W-1:0] idx(input logic [ID_W-1:0] id);
		return IDX_W'(id);
	endfunction

	function automatic logic [IDX_W-1:0] inc_ptr(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	state_t                 state_q;
	req_t                   req_q;
	logic [ID_W-1:0]        tid_q;
	logic [QV_IN_W-1:0]     qv_q;
	logic [ID_W-1:0]        idle_q;
	logic [ID_W-1:0]        cur_q;
	logic [QW-1:0]          ticks_q;
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NUM_TASKS-1:0]   ready_q;
	logic                   next_ok_q;
	logic                   out_valid_q;
	logic                   switched_q;
	logic [ID_W-1:0]        running_q;
	logic [TICKS_OUT_W-1:0] ticks_out_q;
	logic [CNT_OUT_W-1:0]   count_out_q;
	logic                   status_q;

	mem_cmd_t        fifo_cmd;
	logic [ID_W-1:0] fifo_rd;
	logic [ID_W-1:0] fifo_wr_data;
	mem_cmd_t        qtab_cmd;
	logic [IDX_W-1:0] qtab_rd_addr;
	logic [QW-1:0]   qtab_rd;

	logic            accept;
	logic            out_free;
	logic [QW-1:0]   ticks_dec;
	logic            have_ready;
	logic            cur_idle;
	logic            tick_sw;
	logic            mr_ok;
	logic            goes_load;
	logic [ID_W-1:0] next_id;
	logic            exec_fire;
	logic            load_fire;
	logic            out_set;
	logic            push;
	logic            pop;
	logic [CNT_W-1:0] cnt_nxt;
	logic [QW-1:0]   ticks_nxt;
	logic            status_nxt;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ticks_dec  = (ticks_q == '0) ? '0 : ticks_q - 1'b1;
		have_ready = (cnt_q != '0);
		cur_idle   = (cur_q == idle_q);
		tick_sw    = (cur_idle || ticks_dec == '0) && have_ready;
		mr_ok      = in_range(tid_q) && (tid_q != idle_q) && (tid_q != cur_q) &&
			(cnt_q != FULL_CNT) && !ready_q[idx(tid_q)];
		next_id    = fifo_rd;
		goes_load  = 1'b0;
		pop        = 1'b0;
		push       = 1'b0;
		ticks_nxt  = ticks_q;
		status_nxt = 1'b0;
		case (req_q)
			REQ_TICK: begin
				goes_load = tick_sw;
				pop       = tick_sw;
				push      = tick_sw && !cur_idle;
				ticks_nxt = ticks_dec;
			end
			REQ_MAKE_READY: begin
				push       = mr_ok;
				status_nxt = !mr_ok;
			end
			REQ_BLOCK: begin
				goes_load  = !cur_idle;
				pop        = !cur_idle && have_ready;
				next_id    = have_ready ? fifo_rd : idle_q;
				status_nxt = cur_idle;
			end
			REQ_SET_QUANTUM: begin
				status_nxt = !in_range(tid_q);
			end
			default: begin
				status_nxt = 1'b0;
			end
		endcase
		exec_fire = (state_q == S_EXEC) && (goes_load || out_free);
		load_fire = (state_q == S_LOAD) && out_free;
		out_set   = (exec_fire && !goes_load) || load_fire;
		pop       = pop && exec_fire;
		push      = push && exec_fire;
		cnt_nxt   = cnt_q;
		if (push && !pop) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (pop && !push) begin
			cnt_nxt = cnt_q - 1'b1;
		end
	end

	always_comb begin
		fifo_cmd.rd_en = accept;
		fifo_cmd.wr_en = push;
		fifo_wr_data   = (req_q == REQ_TICK) ? cur_q : tid_q;
		qtab_cmd.rd_en = exec_fire && goes_load;
		qtab_cmd.wr_en = exec_fire && (req_q == REQ_SET_QUANTUM) && in_range(tid_q);
		qtab_rd_addr   = in_range(next_id) ? idx(next_id) : '0;
	end

	rrqs_fifo_mem #(
		.DEPTH(NUM_TASKS),
		.AW(IDX_W)
	) u_fifo (
		.clk(clk),
		.cmd(fifo_cmd),
		.rd_addr(head_q),
		.wr_addr(tail_q),
		.wr_data(fifo_wr_data),
		.rd_data(fifo_rd)
	);

	rrqs_qtab_mem #(
		.DEPTH(NUM_TASKS),
		.AW(IDX_W),
		.QW(QW)
	) u_qtab (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(qtab_cmd),
		.rd_addr(qtab_rd_addr),
		.wr_addr(idx(tid_q)),
		.wr_data(QW'(qv_q)),
		.rd_data(qtab_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= REQ_TICK;
			tid_q       <= '0;
			qv_q        <= '0;
			idle_q      <= '0;
			cur_q       <= ID_W'(RESET_TASK);
			ticks_q     <= QW'(INIT_SLICE);
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			ready_q     <= '0;
			next_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			switched_q  <= 1'b0;
			running_q   <= '0;
			ticks_out_q <= '0;
			count_out_q <= '0;
			status_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				idle_q <= cfg_wr_data;
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q   <= req_t'(req_type);
						tid_q   <= task_id;
						qv_q    <= quantum_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						if (pop) begin
							head_q <= inc_ptr(head_q);
						end
						if (push) begin
							tail_q <= inc_ptr(tail_q);
						end
						cnt_q <= cnt_nxt;
						if (push) begin
							if (req_q == REQ_TICK) begin
								if (in_range(cur_q)) begin
									ready_q[idx(cur_q)] <= 1'b1;
								end
							end else begin
								ready_q[idx(tid_q)] <= 1'b1;
							end
						end
						if (goes_load) begin
							if (in_range(next_id)) begin
								ready_q[idx(next_id)] <= 1'b0;
							end
							cur_q     <= next_id;
							next_ok_q <= in_range(next_id);
							state_q   <= S_LOAD;
						end else begin
							ticks_q     <= ticks_nxt;
							switched_q  <= 1'b0;
							running_q   <= cur_q;
							ticks_out_q <= TICKS_OUT_W'(ticks_nxt);
							count_out_q <= CNT_OUT_W'(cnt_nxt);
							status_q    <= status_nxt;
							state_q     <= S_IDLE;
						end
					end
				end
				S_LOAD: begin
					if (load_fire) begin
						ticks_q     <= next_ok_q ? qtab_rd : '0;
						switched_q  <= 1'b1;
						running_q   <= cur_q;
						ticks_out_q <= TICKS_OUT_W'(next_ok_q ? qtab_rd : '0);
						count_out_q <= CNT_OUT_W'(cnt_q);
						status_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign switched        = switched_q;
	assign running_task    = running_q;
	assign remaining_ticks = ticks_out_q;
	assign ready_count     = count_out_q;
	assign status          = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("ready FIFO count exceeds the number of tasks");

	a_running_not_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_range(cur_q) |-> !ready_q[idx(cur_q)])
		else $error("running task is marked ready");

	a_fifo_port_split: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_cmd.rd_en && fifo_cmd.wr_en))
		else $error("FIFO read and write issued in the same cycle");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted item did not enter execution");

	a_load_reports_switch: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> out_valid_q && switched_q)
		else $error("dispatch finished without a switched result");

endmodule

// File: tb/tb.sv
module tb;
	import rrqs_pkg::*;

	localparam int TASKS       = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 650;

	typedef enum logic [1:0] {
		T_BLOCKED = 2'd0,
		T_READY   = 2'd1,
		T_RUNNING = 2'd2
	} task_state_t;

	typedef struct packed {
		logic       sw;
		logic [3:0] run_id;
		logic [7:0] ticks;
		logic [4:0] count;
		logic       rejected;
	} sched_view_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic [3:0] task_id;
	logic [7:0] quantum_value;
	logic       out_valid;
	logic       out_ready;
	logic       switched;
	logic [3:0] running_task;
	logic [7:0] remaining_ticks;
	logic [4:0] ready_count;
	logic       status;

	logic [3:0]  run_queue [TASKS];
	logic [3:0]  rq_head;
	logic [3:0]  rq_tail;
	logic [4:0]  rq_count;
	logic [7:0]  slice_len [TASKS];
	task_state_t task_st [TASKS];
	logic [3:0]  cur_task;
	logic [7:0]  ticks_rem;
	logic [3:0]  idle_id;

	sched_view_t expected_views[$];

	int send_gap_pct;
	int recv_stall_pct;
	int mismatches;
	int results_seen;
	int dispatches_seen;
	int rejects_seen;
	int cycles;

	round_robin_quantum_scheduler u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.task_id        (task_id),
		.quantum_value  (quantum_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.switched       (switched),
		.running_task   (running_task),
		.remaining_ticks(remaining_ticks),
		.ready_count    (ready_count),
		.status         (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic reset_scheduler_model();
		rq_head = '0;
		rq_tail = '0;
		rq_count = '0;
		for (int i = 0; i < TASKS; i++) begin
			run_queue[i] = '0;
			slice_len[i] = 8'(INIT_SLICE);
			task_st[i] = T_BLOCKED;
		end
		task_st[RESET_TASK] = T_RUNNING;
		cur_task = 4'(RESET_TASK);
		ticks_rem = 8'(INIT_SLICE);
		idle_id = '0;
	endtask

	function automatic sched_view_t schedule_event(input req_t kind, input logic [3:0] id,
			input logic [7:0] qv);
		sched_view_t v;
		logic [3:0]  nxt;
		v = '0;
		case (kind)
			REQ_TICK: begin
				if (ticks_rem != 0)
					ticks_rem--;
				if ((cur_task == idle_id || ticks_rem == 0) && rq_count != 0) begin
					nxt = run_queue[rq_head];
					rq_head++;
					rq_count--;
					if (cur_task != idle_id) begin
						task_st[cur_task] = T_READY;
						run_queue[rq_tail] = cur_task;
						rq_tail++;
						rq_count++;
					end else begin
						task_st[cur_task] = T_BLOCKED;
					end
					task_st[nxt] = T_RUNNING;
					cur_task = nxt;
					ticks_rem = slice_len[nxt];
					v.sw = 1'b1;
				end
			end
			REQ_MAKE_READY: begin
				if (id == idle_id || task_st[id] != T_BLOCKED || rq_count >= TASKS) begin
					v.rejected = 1'b1;
				end else begin
					task_st[id] = T_READY;
					run_queue[rq_tail] = id;
					rq_tail++;
					rq_count++;
				end
			end
			REQ_BLOCK: begin
				if (cur_task == idle_id) begin
					v.rejected = 1'b1;
				end else begin
					task_st[cur_task] = T_BLOCKED;
					nxt = idle_id;
					if (rq_count != 0) begin
						nxt = run_queue[rq_head];
						rq_head++;
						rq_count--;
					end
					task_st[nxt] = T_RUNNING;
					cur_task = nxt;
					ticks_rem = slice_len[nxt];
					v.sw = 1'b1;
				end
			end
			default: begin
				slice_len[id] = qv;
			end
		endcase
		v.run_id = cur_task;
		v.ticks = ticks_rem;
		v.count = rq_count;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch in %s at result %0d: got %0d, expected %0d",
			what, results_seen, got, want);
	endtask

	task automatic send_event(input req_t kind, input logic [3:0] id, input logic [7:0] qv);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		expected_views.push_back(schedule_event(kind, id, qv));
		in_valid <= 1'b1;
		req_type <= kind;
		task_id <= id;
		quantum_value <= qv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idle_task(input logic [3:0] id);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= id;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		idle_id = id;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		sched_view_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_views.size() == 0) begin
				report_mismatch("result with no event pending", 1, 0);
			end else begin
				want = expected_views.pop_front();
				if (switched !== want.sw)
					report_mismatch("switched", int'(switched), int'(want.sw));
				if (running_task !== want.run_id)
					report_mismatch("running_task", int'(running_task), int'(want.run_id));
				if (remaining_ticks !== want.ticks)
					report_mismatch("remaining_ticks", int'(remaining_ticks),
						int'(want.ticks));
				if (ready_count !== want.count)
					report_mismatch("ready_count", int'(ready_count), int'(want.count));
				if (status !== want.rejected)
					report_mismatch("status", int'(status), int'(want.rejected));
				dispatches_seen += int'(want.sw);
				rejects_seen += int'(want.rejected);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results still pending", expected_views.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_quantum_setup();
		send_event(REQ_SET_QUANTUM, 4'd2, 8'd0);
		send_event(REQ_SET_QUANTUM, 4'd3, 8'd255);
	endtask

	task automatic test_make_ready_rules();
		send_event(REQ_MAKE_READY, 4'd2, 8'h00);
		send_event(REQ_MAKE_READY, 4'd2, 8'hff);
		send_event(REQ_MAKE_READY, 4'd1, 8'h00);
		send_event(REQ_MAKE_READY, 4'd0, 8'hff);
		send_event(REQ_MAKE_READY, 4'd3, 8'h00);
	endtask

	task automatic test_expiry_and_saturation();
		send_event(REQ_BLOCK, 4'd0, 8'h00);
		send_event(REQ_TICK, 4'd15, 8'hff);
		send_event(REQ_TICK, 4'd0, 8'h00);
	endtask

	task automatic test_block_down_to_idle();
		send_event(REQ_BLOCK, 4'd0, 8'h00);
		send_event(REQ_BLOCK, 4'd0, 8'h00);
		send_event(REQ_BLOCK, 4'd0, 8'h00);
		send_event(REQ_TICK, 4'd0, 8'h00);
	endtask

	task automatic test_leave_idle();
		send_event(REQ_MAKE_READY, 4'd15, 8'h00);
		send_event(REQ_TICK, 4'd0, 8'h00);
	endtask

	task automatic test_idle_reassigned();
		set_idle_task(4'd15);
		send_event(REQ_BLOCK, 4'd0, 8'h00);
		send_event(REQ_MAKE_READY, 4'd15, 8'h00);
	endtask

	task automatic test_random_events(input int count, input int gap_pct, input int stall_pct,
			input logic [3:0] idle);
		int         r;
		req_t       kind;
		logic [7:0] qv;
		set_idle_task(idle);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			r = int'($urandom_range(99));
			if (r < 40)
				kind = REQ_TICK;
			else if (r < 70)
				kind = REQ_MAKE_READY;
			else if (r < 85)
				kind = REQ_BLOCK;
			else
				kind = REQ_SET_QUANTUM;
			if ($urandom_range(99) < 75)
				qv = 8'($urandom_range(12, 0));
			else
				qv = 8'($urandom_range(255, 0));
			send_event(kind, 4'($urandom_range(15, 0)), qv);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_TICK;
		task_id <= '0;
		quantum_value <= '0;
		out_ready <= 1'b0;
		send_gap_pct = 37;
		recv_stall_pct = 65;
		reset_scheduler_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle_task(4'd0);

		test_quantum_setup();
		test_make_ready_rules();
		test_expiry_and_saturation();
		test_block_down_to_idle();
		test_leave_idle();
		test_idle_reassigned();
		test_random_events(PHASE_ITEMS, 37, 65, 4'd15);
		test_random_events(PHASE_ITEMS, 65, 37, 4'd0);
		test_random_events(PHASE_ITEMS, 0, 0, 4'($urandom_range(14, 1)));

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Checked %0d scheduler results: %0d task switches, %0d rejected events.",
			results_seen, dispatches_seen, rejects_seen);
		$display("Idle task ids 0, 15 and one in between, under sender and receiver stalls.");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: round_robin_quantum_scheduler.f
rtl/core/rrqs_pkg.sv
rtl/core/rrqs_fifo_mem.sv
rtl/core/rrqs_qtab_mem.sv
rtl/core/round_robin_quantum_scheduler.sv
tb/tb.sv
